FILE: rtl/core/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, register indexes, verdict codes and the byte-wide CRC step
// for the Modbus RTU frame checker.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] FN_READ_INPUT   = 8'h04;
  localparam logic [7:0] FN_WRITE_COILS  = 8'h0F;
  localparam logic [7:0] FN_WRITE_REGS   = 8'h10;

  // configuration register indexes
  localparam logic CFG_OWN_ADDRESS  = 1'b0;
  localparam logic CFG_WEAK_ADDRESS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SIZE        = 3'd1,
    ST_ADDRESS     = 3'd2,
    ST_CRC         = 3'd3,
    ST_EXCEPTION   = 3'd4,
    ST_READ_SHAPE  = 3'd5,
    ST_WRITE_SHAPE = 3'd6,
    ST_OVERFLOW    = 3'd7
  } status_t;

  // frame summary handed from the tracker to the verdict logic
  typedef struct packed {
    logic        full;
    logic        short_frame;
    logic        odd_length;
    logic [7:0]  address;
    logic [7:0]  func;
    logic [15:0] crc_calc;
    logic [15:0] crc_got;
  } frame_info_t;

  // reflected crc-16, one byte, bit-serial unrolled over eight steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/mrtu_frame.sv
// ----------------------------------------------------------------------------
// mrtu_frame
// Gathers one frame: byte count, address and function bytes, and a running
// CRC that trails the input by two bytes so the last two are the received CRC.
// ----------------------------------------------------------------------------
module mrtu_frame #(
  parameter int FRAME_CAPACITY = 256,
  parameter int CNT_W          = $clog2(FRAME_CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 clear,
  input  logic [7:0]           data_byte,
  output logic [CNT_W-1:0]     count,
  output mrtu_pkg::frame_info_t info
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       older_r, older_nxt;
  logic [7:0]       newer_r, newer_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       func_r, func_nxt;
  logic             full;

  assign full = (cnt_r == CNT_W'(FRAME_CAPACITY));

  always_comb begin
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    if (clear) begin
      cnt_nxt   = '0;
      crc_nxt   = mrtu_pkg::CRC_INIT;
      older_nxt = '0;
      newer_nxt = '0;
      addr_nxt  = '0;
      func_nxt  = '0;
    end else if (push && !full) begin
      if (cnt_r == CNT_W'(0)) begin
        addr_nxt = data_byte;
      end
      if (cnt_r == CNT_W'(1)) begin
        func_nxt = data_byte;
      end
      // crc covers everything but the two newest bytes
      if (cnt_r >= CNT_W'(2)) begin
        crc_nxt = mrtu_pkg::crc_byte(crc_r, older_r);
      end
      older_nxt = newer_r;
      newer_nxt = data_byte;
      cnt_nxt   = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      crc_r   <= mrtu_pkg::CRC_INIT;
      older_r <= '0;
      newer_r <= '0;
      addr_r  <= '0;
      func_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
    end
  end

  assign count            = cnt_r;
  assign info.full        = full;
  assign info.short_frame = (cnt_r < CNT_W'(4));
  assign info.odd_length  = cnt_r[0];
  assign info.address     = addr_r;
  assign info.func        = func_r;
  assign info.crc_calc    = crc_r;
  assign info.crc_got     = {newer_r, older_r};

endmodule

FILE: rtl/core/mrtu_judge.sv
// ----------------------------------------------------------------------------
// mrtu_judge
// Verdict on a gathered frame, checks taken in priority order.
// ----------------------------------------------------------------------------
module mrtu_judge (
  input  mrtu_pkg::frame_info_t info,
  input  logic [7:0]            own_address,
  input  logic [7:0]            weak_address,
  output mrtu_pkg::status_t     status
);

  logic addr_reject;
  logic read_fn;
  logic write_fn;

  // a zero weak address turns the filter off
  assign addr_reject = (info.address != own_address) && (info.address != 8'h00) &&
                       (weak_address != 8'h00) && (info.address != weak_address);

  assign read_fn  = (info.func == mrtu_pkg::FN_READ_HOLDING) ||
                    (info.func == mrtu_pkg::FN_READ_INPUT);
  assign write_fn = (info.func == mrtu_pkg::FN_WRITE_COILS) ||
                    (info.func == mrtu_pkg::FN_WRITE_REGS);

  always_comb begin
    priority if (info.full) begin
      status = mrtu_pkg::ST_OVERFLOW;
    end else if (info.short_frame) begin
      status = mrtu_pkg::ST_SIZE;
    end else if (addr_reject) begin
      status = mrtu_pkg::ST_ADDRESS;
    end else if (info.crc_got != info.crc_calc) begin
      status = mrtu_pkg::ST_CRC;
    end else if (info.func[7]) begin
      status = mrtu_pkg::ST_EXCEPTION;
    end else if (read_fn && info.odd_length) begin
      status = mrtu_pkg::ST_READ_SHAPE;
    end else if (write_fn && !info.odd_length) begin
      status = mrtu_pkg::ST_WRITE_SHAPE;
    end else begin
      status = mrtu_pkg::ST_OK;
    end
  end

endmodule

FILE: rtl/core/modbus_rtu_frame_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker
// Checks received Modbus RTU frames and gives one verdict per line break.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat per received byte, or a break
// mark (in_is_break = 1) that ends the frame. Data beats update the frame
// tracker and produce nothing; a break beat produces one result beat.
// Result channel (out_valid/out_ready): status, frame length, address and
// function byte of the frame that just ended.
// One input beat per cycle, but a break stalls while the result register is full.
// A result appears in the output register the cycle after its break is taken;
// the CRC unit takes a byte per cycle. While a result waits, data beats are still
// taken; a new break waits until the result register frees up, which it does in
// the same cycle the waiting result is taken.
// Bytes past FRAME_CAPACITY are dropped; a frame that reaches FRAME_CAPACITY ends as overflow.
// Reset (rst_n low, synchronous) empties the frame, clears the result valid
// flag and sets own address 1 and weak broadcast address 0.
// Configuration is a plain write port: index 0 own address, 1 weak address.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker #(
  parameter int FRAME_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_is_break,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [8:0] out_frame_length,
  output logic [7:0] out_slave_address,
  output logic [7:0] out_function_code
);

  localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

  logic [7:0]            own_r, weak_r;
  logic                  accept;
  logic                  brk_accept;
  logic [CNT_W-1:0]      count;
  mrtu_pkg::frame_info_t info;
  mrtu_pkg::status_t     status;

  logic                  out_valid_r;
  logic [2:0]            status_r;
  logic [8:0]            length_r;
  logic [7:0]            addr_r;
  logic [7:0]            func_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r  <= 8'h01;
      weak_r <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrtu_pkg::CFG_OWN_ADDRESS:  own_r  <= cfg_wdata;
        mrtu_pkg::CFG_WEAK_ADDRESS: weak_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // data beats never need the result register
  assign in_ready   = !in_is_break || !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign brk_accept = accept && in_is_break;

  mrtu_frame #(
    .FRAME_CAPACITY (FRAME_CAPACITY),
    .CNT_W          (CNT_W)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && !in_is_break),
    .clear     (brk_accept),
    .data_byte (in_data_byte),
    .count     (count),
    .info      (info)
  );

  mrtu_judge u_judge (
    .info         (info),
    .own_address  (own_r),
    .weak_address (weak_r),
    .status       (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (brk_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (brk_accept) begin
      status_r <= status;
      length_r <= 9'(count);
      addr_r   <= info.address;
      func_r   <= info.func;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_frame_length  = length_r;
  assign out_slave_address = addr_r;
  assign out_function_code = func_r;

endmodule

FILE: dv/mrtu_tb_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_tb_pkg
// Verdict prediction for the Modbus RTU frame checker bench: a byte-wise
// CRC-16 step and a small scoreboard that follows every accepted beat and
// compares each result beat with the oldest predicted verdict.
// ----------------------------------------------------------------------------
package mrtu_tb_pkg;

  import mrtu_pkg::*;

  localparam int FRAME_CAPACITY = 256;

  // reflected crc-16, one data bit at a time
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  typedef struct packed {
    status_t    status;
    logic [8:0] length;
    logic [7:0] address;
    logic [7:0] func;
  } verdict_t;

  class frame_verdict_board;
    logic [7:0]  own_addr;
    logic [7:0]  weak_addr;
    logic [15:0] crc_acc;
    int unsigned count;
    logic [7:0]  older;
    logic [7:0]  newer;
    logic [7:0]  addr_b;
    logic [7:0]  func_b;
    verdict_t    pending_verdicts[$];
    int unsigned mismatch_count;
    int unsigned results_seen;

    function new();
      own_addr = 8'h01;
      weak_addr = 8'h00;
      mismatch_count = 0;
      results_seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc_acc = CRC_INIT;
      count = 0;
      older = 8'h00;
      newer = 8'h00;
      addr_b = 8'h00;
      func_b = 8'h00;
    endfunction

    function void write_register(input logic idx, input logic [7:0] val);
      if (idx == CFG_OWN_ADDRESS) begin
        own_addr = val;
      end else begin
        weak_addr = val;
      end
    endfunction

    function status_t judge();
      if (count >= FRAME_CAPACITY) return ST_OVERFLOW;
      if (count < 4) return ST_SIZE;
      if (addr_b != own_addr && addr_b != 8'h00 && weak_addr != 8'h00 && addr_b != weak_addr)
        return ST_ADDRESS;
      // crc arrives low byte first, so the newer held byte is the high half
      if ({newer, older} != crc_acc) return ST_CRC;
      if (func_b[7]) return ST_EXCEPTION;
      if ((func_b == FN_READ_HOLDING || func_b == FN_READ_INPUT) && (count % 2 == 1))
        return ST_READ_SHAPE;
      if ((func_b == FN_WRITE_COILS || func_b == FN_WRITE_REGS) && (count % 2 == 0))
        return ST_WRITE_SHAPE;
      return ST_OK;
    endfunction

    function void note_beat(input logic brk, input logic [7:0] b);
      verdict_t v;
      if (!brk) begin
        if (count < FRAME_CAPACITY) begin
          if (count == 0) begin
            addr_b = b;
          end else if (count == 1) begin
            func_b = b;
          end
          if (count >= 2) crc_acc = crc16_feed(crc_acc, older);
          older = newer;
          newer = b;
          count++;
        end
      end else begin
        v.status = judge();
        v.length = 9'(count);
        v.address = addr_b;
        v.func = func_b;
        pending_verdicts.push_back(v);
        clear_frame();
      end
    endfunction

    task report(input string msg);
      if (mismatch_count < 100) $display("result %0d: %s", results_seen, msg);
      mismatch_count++;
    endtask

    task check_verdict(input status_t st, input logic [8:0] len, input logic [7:0] a,
                       input logic [7:0] f);
      verdict_t want;
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected beat, status %0d length %0d", st, len));
      end else begin
        want = pending_verdicts.pop_front();
        if (st != want.status)
          report($sformatf("status %0d, expected %0d", st, want.status));
        if (len != want.length)
          report($sformatf("frame_length %0d, expected %0d", len, want.length));
        if (a != want.address)
          report($sformatf("slave_address %02h, expected %02h", a, want.address));
        if (f != want.func)
          report($sformatf("function_code %02h, expected %02h", f, want.func));
      end
    endtask

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

endpackage

FILE: dv/modbus_rtu_frame_checker_test.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker_test
// Drives byte and break beats into the frame checker with random gaps on
// both channels, rewrites the address registers between phases, and checks
// every verdict against a scoreboard that follows the accepted beats.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker_test;

  timeunit 1ns;
  timeprecision 1ps;

  import mrtu_pkg::*;
  import mrtu_tb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEM_TARGET  = 1700;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic       brk;
    logic [7:0] b;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_is_break = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [8:0] out_frame_length;
  logic [7:0] out_slave_address;
  logic [7:0] out_function_code;

  frame_verdict_board board;
  beat_t       stim_q[$];
  logic [7:0]  cur_own = 8'h01;
  logic [7:0]  cur_weak = 8'h00;
  bit          tx_eager = 1'b0;
  bit          rx_eager = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;

  modbus_rtu_frame_checker #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_is_break       (in_is_break),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_frame_length  (out_frame_length),
    .out_slave_address (out_slave_address),
    .out_function_code (out_function_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("modbus_rtu_frame_checker: mismatch");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    stim_q.push_back('{1'b0, b});
  endtask

  task automatic push_break();
    stim_q.push_back('{1'b1, 8'($urandom)});
  endtask

  // n bytes in all, the last two carry the crc low byte first
  task automatic push_frame(input logic [7:0] a, input logic [7:0] f, input int n,
                            input bit crc_ok);
    logic [7:0]  fr[$];
    logic [15:0] c;
    int          pos;
    fr.push_back(a);
    fr.push_back(f);
    for (int i = 2; i < n - 2; i++) fr.push_back(8'($urandom));
    c = CRC_INIT;
    foreach (fr[i]) c = crc16_feed(c, fr[i]);
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    if (!crc_ok) begin
      pos = $urandom_range(0, n - 1);
      fr[pos] = fr[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (fr[i]) push_byte(fr[i]);
    push_break();
  endtask

  function automatic logic [7:0] pick_address();
    case ($urandom_range(0, 4))
      0: return cur_own;
      1: return 8'h00;
      2: return cur_weak;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_function();
    case ($urandom_range(0, 7))
      0: return FN_READ_HOLDING;
      1: return FN_READ_INPUT;
      2: return FN_WRITE_COILS;
      3: return FN_WRITE_REGS;
      4: return 8'($urandom) | 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_random_frame();
    int         kind;
    int         n;
    logic [7:0] a;
    logic [7:0] f;
    kind = $urandom_range(0, 99);
    a = pick_address();
    f = pick_function();
    if (kind < 62) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(4, 24);
      // mostly keep the reply shape that the function code asks for
      if ($urandom_range(0, 3) != 0) begin
        if (f == FN_READ_HOLDING || f == FN_READ_INPUT) n = n & ~1;
        if (f == FN_WRITE_COILS || f == FN_WRITE_REGS) n = n | 1;
      end
      push_frame(a, f, n, $urandom_range(0, 6) != 0);
    end else if (kind < 74) begin
      n = $urandom_range(0, 3);
      if (n > 0) push_byte(a);
      if (n > 1) push_byte(f);
      if (n > 2) push_byte(8'($urandom));
      push_break();
    end else if (kind < 92) begin
      n = $urandom_range(4, 30);
      push_byte(a);
      for (int i = 1; i < n; i++) push_byte(8'($urandom));
      push_break();
    end else begin
      push_break();
    end
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom));
    push_break();
  endtask

  task automatic send_all();
    beat_t beat;
    int    gap;
    while (stim_q.size() != 0) begin
      beat = stim_q.pop_front();
      gap = tx_eager ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_is_break <= beat.brk;
      in_data_byte <= beat.b;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      board.note_beat(beat.brk, beat.b);
      items_sent++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_config(input logic [7:0] own, input logic [7:0] group_addr);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_wdata <= own;
    @(posedge clk);
    board.write_register(CFG_OWN_ADDRESS, own);
    cfg_index <= CFG_WEAK_ADDRESS;
    cfg_wdata <= group_addr;
    @(posedge clk);
    board.write_register(CFG_WEAK_ADDRESS, group_addr);
    cfg_we <= 1'b0;
    cur_own = own;
    cur_weak = group_addr;
  endtask

  // data beats give no result, so wait for the last pending verdict, then idle
  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side
  initial begin
    int gap;
    int hold_left;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_eager ? 0 : $urandom_range(0, 16);
      if (long_hold) begin
        long_hold = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_verdict(status_t'(out_status), out_frame_length, out_slave_address,
                          out_function_code);
    end
  end

  initial begin
    int phase;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: filter off, own address 1
    push_break();
    push_byte(8'hFF);
    push_byte(8'h00);
    push_break();
    push_frame(8'h01, 8'h06, 4, 1'b1);
    push_frame(8'h01, 8'h06, 4, 1'b0);
    push_frame(8'h01, 8'h83, 4, 1'b1);
    push_frame(8'h01, FN_READ_HOLDING, 5, 1'b1);
    send_all();
    wait_drained();

    phase = 1;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        1: write_config(8'hFF, 8'h80);
        2: write_config(8'h00, 8'hFF);
        3: write_config(8'($urandom), 8'h00);
        4: write_config(8'h7F, 8'h01);
        default: write_config(8'($urandom), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      endcase
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        push_frame(8'h55, 8'h06, 4, 1'b1);
        push_frame(8'h80, FN_WRITE_REGS, 4, 1'b1);
        push_frame(8'h00, FN_WRITE_COILS, 5, 1'b1);
      end
      if (phase == 2) begin
        // exactly full, then past capacity with dropped bytes
        push_noise(FRAME_CAPACITY);
        push_noise(FRAME_CAPACITY + 3);
      end
      if (phase == 3) begin
        long_hold = 1'b1;
        tx_eager = 1'b1;
      end
      for (int i = 0; i < 16; i++) push_random_frame();
      send_all();
      wait_drained();
      phase++;
    end

    wait_drained();
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("modbus_rtu_frame_checker: match");
    end else begin
      $display("modbus_rtu_frame_checker: mismatch");
    end
    $finish;
  end

endmodule

FILE: modbus_rtu_frame_checker.f
rtl/core/mrtu_pkg.sv
rtl/core/mrtu_frame.sv
rtl/core/mrtu_judge.sv
rtl/core/modbus_rtu_frame_checker.sv
dv/mrtu_tb_pkg.sv
dv/modbus_rtu_frame_checker_test.sv
